// ----- rtl/u2c_pkg.sv -----
// Shared types and constants for the UTF-8 to code point decoder.
package u2c_pkg;

  localparam int unsigned ByteWidth = 8;
  localparam int unsigned CpWidth = 21;
  localparam int unsigned PendWidth = 2;
  localparam int unsigned ResultDepth = 3;

  typedef struct packed {
    logic               has_code_point;
    logic [CpWidth-1:0] code_point;
    logic               end_of_string;
    logic               stopped_early;
  } u2c_result_t;

endpackage

// ----- rtl/utf8_to_codepoint_decoder.sv -----
// Top level of the UTF-8 to code point decoder.
// A byte is held in the input register and its result is written to the result queue before it is offered.
// Throughput: one byte per cycle while in_stall_o is low; the input register passes each accepted byte to the decoder.
// The result queue holds ResultDepth requests and stalls input only when it could fill.
// Reset clears the sequence state, the input register valid and the result queue.
module utf8_to_codepoint_decoder #(
  parameter int unsigned ResultDepth = u2c_pkg::ResultDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [u2c_pkg::ByteWidth-1:0] byte_in_i,
  input  logic                          string_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          has_code_point_o,
  output logic [u2c_pkg::CpWidth-1:0]   code_point_o,
  output logic                          end_of_string_o,
  output logic                          stopped_early_o
);

  localparam int unsigned LvlWidth = $clog2(ResultDepth + 1);

  logic                          in_valid_q;
  logic [u2c_pkg::ByteWidth-1:0] byte_q;
  logic                          last_q;
  logic                          push;
  u2c_pkg::u2c_result_t          dec_result;
  u2c_pkg::u2c_result_t          out_result;
  logic [LvlWidth-1:0]           level;
  logic [LvlWidth:0]             occupancy;

  assign occupancy  = {1'b0, level} + (LvlWidth + 1)'(in_valid_q);
  assign in_stall_o = (occupancy >= (LvlWidth + 1)'(ResultDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_i && !in_stall_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= byte_in_i;
      last_q <= string_end_i;
    end
  end

  u2c_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_q),
    .byte_i   (byte_q),
    .last_i   (last_q),
    .push_o   (push),
    .result_o (dec_result)
  );

  u2c_result_fifo #(
    .Depth (ResultDepth)
  ) u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (dec_result),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_result),
    .level_o (level)
  );

  assign has_code_point_o = out_result.has_code_point;
  assign code_point_o     = out_result.code_point;
  assign end_of_string_o  = out_result.end_of_string;
  assign stopped_early_o  = out_result.stopped_early;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (level < LvlWidth'(ResultDepth)) || (out_valid_o && !out_stall_i))
    else $error("Result queue written while full.");

  a_result_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> dec_result.has_code_point || dec_result.end_of_string)
    else $error("Result written with neither code point nor end of string.");

  a_early_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stopped_early_o |-> end_of_string_o)
    else $error("Early stop reported without end of string.");

  a_no_request_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !push)
    else $error("Result produced without an input request.");

endmodule

// ----- rtl/u2c_decode.sv -----
// Byte decoder with the sequence state and the result decision.
module u2c_decode (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [u2c_pkg::ByteWidth-1:0]   byte_i,
  input  logic                            last_i,
  output logic                            push_o,
  output u2c_pkg::u2c_result_t            result_o
);

  logic [u2c_pkg::PendWidth-1:0] pend_q, pend_d;
  logic [u2c_pkg::CpWidth-1:0]   part_q, part_d;
  logic                          halt_q, halt_d;
  logic                          got;
  logic [u2c_pkg::CpWidth-1:0]   cp;
  logic [u2c_pkg::CpWidth-1:0]   shifted;

  assign shifted = {part_q[u2c_pkg::CpWidth-7:0], byte_i[5:0]};

  always_comb begin
    pend_d   = pend_q;
    part_d   = part_q;
    halt_d   = halt_q;
    got      = 1'b0;
    cp       = '0;
    push_o   = 1'b0;
    result_o = '0;
    if (valid_i) begin
      if (!halt_q) begin
        if (pend_q == '0) begin
          unique casez (byte_i)
            8'b0???????: begin
              got = 1'b1;
              cp  = {{(u2c_pkg::CpWidth-8){1'b0}}, byte_i};
            end
            8'b110?????: begin
              part_d = {{(u2c_pkg::CpWidth-5){1'b0}}, byte_i[4:0]};
              pend_d = 2'd1;
            end
            8'b1110????: begin
              part_d = {{(u2c_pkg::CpWidth-4){1'b0}}, byte_i[3:0]};
              pend_d = 2'd2;
            end
            8'b11110???: begin
              part_d = {{(u2c_pkg::CpWidth-3){1'b0}}, byte_i[2:0]};
              pend_d = 2'd3;
            end
            default: begin
              halt_d = 1'b1;
            end
          endcase
        end else if (byte_i[7:6] != 2'b10) begin
          halt_d = 1'b1;
          pend_d = '0;
          part_d = '0;
        end else begin
          pend_d = pend_q - 2'd1;
          if (pend_q == 2'd1) begin
            got    = 1'b1;
            cp     = shifted;
            part_d = '0;
          end else begin
            part_d = shifted;
          end
        end
      end
      push_o                  = got || last_i;
      result_o.has_code_point = got;
      result_o.code_point     = cp;
      result_o.end_of_string  = last_i;
      result_o.stopped_early  = last_i && (halt_d || (pend_d != '0));
      if (last_i) begin
        pend_d = '0;
        part_d = '0;
        halt_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      part_q <= '0;
      halt_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      part_q <= part_d;
      halt_q <= halt_d;
    end
  end

endmodule

// ----- rtl/u2c_result_fifo.sv -----
// Small result queue that holds decoded requests until the consumer takes them.
module u2c_result_fifo #(
  parameter int unsigned Depth = u2c_pkg::ResultDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  u2c_pkg::u2c_result_t          data_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output u2c_pkg::u2c_result_t          data_o,
  output logic [$clog2(Depth+1)-1:0]    level_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  u2c_pkg::u2c_result_t  mem_q [Depth];
  logic [PtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic                  pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rd_ptr_q];
  assign level_o = cnt_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + CntWidth'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
